// File: src/scaled_inverse_hypot_stream_macros.svh
// Assertion macros for the scaled inverse hypot stream block.
// Each use expects clk and arst_n in scope.
`ifndef SCALED_INVERSE_HYPOT_STREAM_MACROS_SVH
`define SCALED_INVERSE_HYPOT_STREAM_MACROS_SVH
`ifndef ASSERT_OFF
`define SIH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SIH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SIH_ASSERT(lbl, prop, msg)
`define SIH_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/sih_pkg.sv
package sih_pkg;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] ABS_MASK  = 32'h7FFF_FFFF;
	localparam logic [31:0] SCALE_RST = 32'h3F80_0000;  // 1.0
	localparam logic [31:0] FLOOR_RST = 32'h0000_0000;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE = 2'd0,
		REG_FLOOR = 2'd1
	} cfg_reg_e;

	// wide exponent, holds squared and shifted values without wrap
	typedef logic signed [11:0] exp_t;

	typedef struct packed {
		logic [23:0] m;
		exp_t        e;
	} split_t;

	typedef struct packed {
		logic [31:0] val;
		logic        last;
	} item_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b & ABS_MASK) > INF_BITS;
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return (b & ABS_MASK) == INF_BITS;
	endfunction

	function automatic logic is_zero(input logic [31:0] b);
		return (b & ABS_MASK) == 32'd0;
	endfunction

	// finite nonzero pattern -> m * 2^e, bit 23 of m set
	function automatic split_t split_fp(input logic [31:0] b);
		split_t r;
		logic [4:0] sh;
		sh = '0;
		for (int i = 0; i < 23; i++) begin
			if (b[i]) sh = 5'(23 - i);
		end
		if (b[30:23] != 8'd0) begin
			r.m = {1'b1, b[22:0]};
			r.e = exp_t'({4'b0, b[30:23]}) - exp_t'(150);
		end else begin
			r.m = {1'b0, b[22:0]} << sh;
			r.e = exp_t'(-149) - exp_t'({7'b0, sh});
		end
		return r;
	endfunction

	// r has its msb at bit 63, worth 2^lead; round to nearest even
	function automatic logic [31:0] round_fp(input logic [63:0] r, input logic sticky,
			input exp_t lead);
		logic [127:0] t;
		logic [6:0] s;
		logic [63:0] q;
		logic up;
		exp_t d;
		logic [7:0] e8;
		d = exp_t'(-86) - lead;
		if (lead >= exp_t'(-126)) s = 7'd40;
		else s = (d > exp_t'(65)) ? 7'd65 : d[6:0];
		t = {r, 64'b0} >> s;
		q = t[127:64];
		up = t[63] & ((|t[62:0]) | sticky | q[0]);
		q = q + {63'b0, up};
		e8 = 8'(lead + exp_t'(126));
		if (lead > exp_t'(127)) return INF_BITS;
		if (lead >= exp_t'(-126)) return {1'b0, e8, 23'b0} + q[31:0];
		return q[31:0];
	endfunction

endpackage

// File: src/scaled_inverse_hypot_stream.sv
// Channel  Handshake            Payload
// s        s_tvalid/s_tready    s_tdata[31:0] element_in, s_tlast last_in
// m        m_tvalid/m_tready    m_tdata[31:0] element_out, m_tlast last_out
// cfg      cfg_valid/cfg_ready  cfg_index (0 scale_factor, 1 floor_offset), cfg_data
//
// One beat per cycle sustained while the skid register is empty; accept to m_tvalid runs
// through multiply, square root with 2 root bits a stage, reciprocal with 2 quotient
// bits a stage, then the output register. All stages move on one enable that drops only
// while the skid register holds a beat, so stalls lose nothing. Reset clears valid
// bits and loads scale_factor = 1.0, floor_offset = 0.
`include "scaled_inverse_hypot_stream_macros.svh"

module scaled_inverse_hypot_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] element_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] element_out
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [sih_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import sih_pkg::*;

	logic [31:0] scale_q, floor_q;
	logic en;
	logic mul_v, hyp_v, rcp_v;
	item_t in_item, mul_item, hyp_item, rcp_item, out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic push, taken;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			floor_q <= FLOOR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_data;
				REG_FLOOR: floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !skid_v_q;
	assign s_tready = en;
	assign in_item = '{val: s_tdata, last: s_tlast};

	sih_mul u_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(s_tvalid),
		.scale(scale_q), .in_item(in_item), .out_v(mul_v), .out_item(mul_item)
	);

	sih_hyp u_hyp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(mul_v),
		.eps(floor_q), .in_item(mul_item), .out_v(hyp_v), .out_item(hyp_item)
	);

	sih_rcp u_rcp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(hyp_v),
		.in_item(hyp_item), .out_v(rcp_v), .out_item(rcp_item)
	);

	assign push = en & rcp_v;
	assign taken = out_v_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || taken) begin
			out_v_q <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || taken) begin
			out_q <= skid_v_q ? skid_q : rcp_item;
		end else if (push) begin
			skid_q <= rcp_item;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q.val;
	assign m_tlast = out_q.last;

	`SIH_NEVER(a_skid_alone, skid_v_q && !out_v_q, "skid holds a beat while output is empty")
	`SIH_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && !m_tready), "skid filled without a stall")
	`SIH_ASSERT(a_scale_hold, (cfg_valid && cfg_index != REG_SCALE) |=> $stable(scale_q), "scale changed by other index")
	`SIH_ASSERT(a_floor_hold, (cfg_valid && cfg_index != REG_FLOOR) |=> $stable(floor_q), "floor changed by other index")

endmodule

// File: src/sih_mul.sv
module sih_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [31:0]     scale,
	input  sih_pkg::item_t  in_item,
	output logic            out_v,
	output sih_pkg::item_t  out_item
);
	import sih_pkg::*;

	logic [31:0] a_abs, x_abs, sval_c;
	split_t sa, sx;
	logic spec_c;

	logic v_s1, v_s2;
	logic [23:0] ma_s1, mx_s1;
	exp_t e_s1, e_s2;
	logic spec_s1, spec_s2, last_s1, last_s2;
	logic [31:0] sval_s1, sval_s2;
	logic [47:0] prod_s2;

	logic [63:0] rn;
	exp_t lead_c;

	always_comb begin
		a_abs = scale & ABS_MASK;
		x_abs = in_item.val & ABS_MASK;
		sa = split_fp(a_abs);
		sx = split_fp(x_abs);
		spec_c = 1'b1;
		sval_c = 32'd0;
		if (is_nan(a_abs) || is_nan(x_abs)) begin
			sval_c = QNAN_BITS;
		end else if (is_inf(a_abs) || is_inf(x_abs)) begin
			sval_c = (is_zero(a_abs) || is_zero(x_abs)) ? QNAN_BITS : INF_BITS;
		end else if (is_zero(a_abs) || is_zero(x_abs)) begin
			sval_c = 32'd0;
		end else begin
			spec_c = 1'b0;
		end
	end

	always_comb begin
		rn = prod_s2[47] ? {prod_s2, 16'b0} : {prod_s2[46:0], 17'b0};
		lead_c = e_s2 + (prod_s2[47] ? exp_t'(47) : exp_t'(46));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= sa.m;
			mx_s1 <= sx.m;
			e_s1 <= sa.e + sx.e;
			spec_s1 <= spec_c;
			sval_s1 <= sval_c;
			last_s1 <= in_item.last;

			prod_s2 <= ma_s1 * mx_s1;
			e_s2 <= e_s1;
			spec_s2 <= spec_s1;
			sval_s2 <= sval_s1;
			last_s2 <= last_s1;

			out_item.val <= spec_s2 ? sval_s2 : round_fp(rn, 1'b0, lead_c);
			out_item.last <= last_s2;
		end
	end

endmodule

// File: src/sih_hyp.sv
module sih_hyp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [31:0]     eps,
	input  sih_pkg::item_t  in_item,
	output logic            out_v,
	output sih_pkg::item_t  out_item
);
	import sih_pkg::*;

	localparam int NSQ = 16;  // two root bits per stage

	typedef struct packed {
		logic [62:0] rem;
		logic [62:0] root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t x, input logic [62:0] bit_v);
		sq_t y;
		logic [63:0] tr;
		tr = {1'b0, x.root} + {1'b0, bit_v};
		if ({1'b0, x.rem} >= tr) begin
			y.rem = x.rem - tr[62:0];
			y.root = (x.root >> 1) + bit_v;
		end else begin
			y.rem = x.rem;
			y.root = x.root >> 1;
		end
		return y;
	endfunction

	logic [31:0] pa, ea, sval_c;
	split_t sp, se;
	logic spec_c;

	logic v_h1;
	logic [47:0] sa_h1, sb_h1;
	exp_t a1_h1, a2_h1;
	logic spec_h1, last_h1;
	logic [31:0] sval_h1;

	logic [47:0] big_c, sml_c;
	exp_t ebig_c, d_c;
	logic [61:0] bs_c, al_c;
	logic [62:0] s_c;
	logic stk_c;

	sq_t  sq_s   [0:NSQ];
	logic v_s    [0:NSQ];
	logic stk_s  [0:NSQ];
	exp_t e_s    [0:NSQ];
	logic spec_s [0:NSQ];
	logic last_s [0:NSQ];
	logic [31:0] sval_s [0:NSQ];

	logic [31:0] rt;
	exp_t e2_c, lead_c;
	logic [63:0] rn;

	always_comb begin
		pa = in_item.val & ABS_MASK;
		ea = eps & ABS_MASK;
		sp = split_fp(pa);
		se = split_fp(ea);
		spec_c = 1'b1;
		sval_c = 32'd0;
		if (is_inf(pa) || is_inf(ea)) begin
			sval_c = INF_BITS;
		end else if (is_nan(pa) || is_nan(ea)) begin
			sval_c = QNAN_BITS;
		end else if (pa == 32'd0) begin
			sval_c = ea;
		end else if (ea == 32'd0) begin
			sval_c = pa;
		end else begin
			spec_c = 1'b0;
		end
	end

	// align the smaller square under the larger one
	always_comb begin
		if (a2_h1 > a1_h1) begin
			big_c = sb_h1;
			sml_c = sa_h1;
			ebig_c = a2_h1;
			d_c = a2_h1 - a1_h1;
		end else begin
			big_c = sa_h1;
			sml_c = sb_h1;
			ebig_c = a1_h1;
			d_c = a1_h1 - a2_h1;
		end
		bs_c = {sml_c, 14'b0};
		al_c = bs_c >> d_c[5:0];
		if (d_c > exp_t'(62)) begin
			s_c = {1'b0, big_c, 14'b0};
			stk_c = 1'b1;
		end else begin
			s_c = {1'b0, big_c, 14'b0} + {1'b0, al_c};
			stk_c = (bs_c ^ (al_c << d_c[5:0])) != 62'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h1 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_h1 <= in_v;
			v_s[0] <= v_h1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_h1 <= sp.m * sp.m;
			sb_h1 <= se.m * se.m;
			a1_h1 <= sp.e + sp.e;
			a2_h1 <= se.e + se.e;
			spec_h1 <= spec_c;
			sval_h1 <= sval_c;
			last_h1 <= in_item.last;

			sq_s[0] <= '{rem: s_c, root: '0};
			stk_s[0] <= stk_c;
			e_s[0] <= ebig_c;
			spec_s[0] <= spec_h1;
			sval_s[0] <= sval_h1;
			last_s[0] <= last_h1;
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		localparam logic [62:0] B0 = 63'(1) << (62 - 4 * k);
		localparam logic [62:0] B1 = 63'(1) << (60 - 4 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= sq_step(sq_step(sq_s[k], B0), B1);
				stk_s[k+1] <= stk_s[k];
				e_s[k+1] <= e_s[k];
				spec_s[k+1] <= spec_s[k];
				sval_s[k+1] <= sval_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	// root lies in [2^30, 2^31.5)
	always_comb begin
		rt = sq_s[NSQ].root[31:0];
		e2_c = (e_s[NSQ] - exp_t'(14)) >>> 1;
		rn = rt[31] ? {rt, 32'b0} : {rt[30:0], 33'b0};
		lead_c = e2_c + (rt[31] ? exp_t'(31) : exp_t'(30));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v <= 1'b0;
		else if (en) out_v <= v_s[NSQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.val <= spec_s[NSQ] ? sval_s[NSQ]
				: round_fp(rn, stk_s[NSQ] | (|sq_s[NSQ].rem), lead_c);
			out_item.last <= last_s[NSQ];
		end
	end

endmodule

// File: src/sih_rcp.sv
module sih_rcp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  sih_pkg::item_t  in_item,
	output logic            out_v,
	output sih_pkg::item_t  out_item
);
	import sih_pkg::*;

	localparam int NDV = 20;  // two quotient bits per stage, 40 in all

	typedef struct packed {
		logic [24:0] rem;
		logic [39:0] q;
	} dv_t;

	function automatic dv_t dv_step(input dv_t x, input logic [23:0] m);
		dv_t y;
		logic [24:0] r;
		r = {x.rem[23:0], 1'b0};
		if (r >= {1'b0, m}) begin
			y.rem = r - {1'b0, m};
			y.q = {x.q[38:0], 1'b1};
		end else begin
			y.rem = r;
			y.q = {x.q[38:0], 1'b0};
		end
		return y;
	endfunction

	split_t sh;
	logic spec_c;
	logic [31:0] sval_c;

	dv_t  dv_s   [0:NDV];
	logic [23:0] m_s [0:NDV];
	logic v_s    [0:NDV];
	exp_t e_s    [0:NDV];
	logic spec_s [0:NDV];
	logic last_s [0:NDV];
	logic [31:0] sval_s [0:NDV];

	logic [39:0] qf;
	logic [63:0] rn;
	exp_t lead_c;

	always_comb begin
		sh = split_fp(in_item.val);
		spec_c = 1'b1;
		sval_c = 32'd0;
		if (is_nan(in_item.val)) sval_c = QNAN_BITS;
		else if (is_inf(in_item.val)) sval_c = 32'd0;
		else if (is_zero(in_item.val)) sval_c = INF_BITS;
		else spec_c = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_v;
	end

	// dividend 2^62: the leading quotient bits are zero, start with 2^22 pending
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= '{rem: 25'(1) << 22, q: '0};
			m_s[0] <= sh.m;
			e_s[0] <= sh.e;
			spec_s[0] <= spec_c;
			sval_s[0] <= sval_c;
			last_s[0] <= in_item.last;
		end
	end

	for (genvar k = 0; k < NDV; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= dv_step(dv_step(dv_s[k], m_s[k]), m_s[k]);
				m_s[k+1] <= m_s[k];
				e_s[k+1] <= e_s[k];
				spec_s[k+1] <= spec_s[k];
				sval_s[k+1] <= sval_s[k];
				last_s[k+1] <= last_s[k];
			end
		end
	end

	always_comb begin
		qf = dv_s[NDV].q;
		rn = qf[39] ? {qf, 24'b0} : {qf[38:0], 25'b0};
		lead_c = exp_t'(-62) - e_s[NDV] + (qf[39] ? exp_t'(39) : exp_t'(38));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v <= 1'b0;
		else if (en) out_v <= v_s[NDV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.val <= spec_s[NDV] ? sval_s[NDV]
				: round_fp(rn, |dv_s[NDV].rem, lead_c);
			out_item.last <= last_s[NDV];
		end
	end

endmodule
